// ----- rtl/core/lhp_pkg.sv -----
// Shared types and constants for the 3x3 Laplacian high-pass unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package lhp_pkg;

   localparam int PixelWidth          = 8;
   localparam int RowLengthWidth      = 11;
   localparam int RowCountWidth       = 13;
   localparam int RowLengthReset      = 512;
   localparam int RowCountReset       = 512;
   localparam int MinDim              = 3;
   localparam int MaxRowLengthDefault = 1024;
   localparam int MaxRowsDefault      = 4096;

   // csr channel
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 13;
   localparam logic [CsrIndexWidth-1:0] CsrRowLength = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrRowCount  = 2'd1;

   // kernel arithmetic: 8*center - neighbors, then /16
   localparam int CenterGainShift = 3;
   localparam int DivShift        = 4;
   localparam int NeighborSumW    = PixelWidth + 3;
   localparam int SumWidth        = NeighborSumW + 1;

   // result queue
   localparam int OutFifoDepth = 4;

   typedef struct packed {
      logic [PixelWidth-1:0] pixel_in;
      logic                  flush;
   } req_payload_type;

   typedef struct packed {
      logic [PixelWidth-1:0] pixel_out;
      logic                  frame_last;
   } rsp_payload_type;

endpackage

// ----- rtl/core/lhp_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lhp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/laplacian_highpass_3x3_unit.sv -----
// Top level of the streaming 3x3 Laplacian high-pass filter.
// Depends on lhp_pkg and lhp_ram (line store).
`timescale 1ns / 1ps

// Usage
//   req_*  : one item per handshake, a gray pixel in raster order or a flush.
//   rsp_*  : filtered pixels in raster order; frame_last marks a frame's end.
//   csr_*  : index 0 = row length, index 1 = row count. Always ready. Any
//            write to a known index restarts the frame. Write only when idle.
// Throughput: one item per clock while the result queue has room. The two previous rows sit in a
//   single line-store RAM (upper row and the row above it side by side),
//   read at the incoming column and written back in the following cycle.
// Pipeline: a pixel's result is produced by the item that arrives one row plus
//   one pixel after it; that item passes the RAM read into the stage-1
//   registers, the kernel sum into the stage-2 registers, then divide/clamp
//   into the queue, which drives rsp_valid.
//   After the frame's last pixel, row_length + 1 more items, flush or pixel, drain the rest.
//   Flush items before the last pixel of the frame are dropped.
// Reset: row length and count go to 512 (clamped to the parameters), the
//   frame position to zero. The line store is not cleared; rows not yet
//   written never feed an output.
// Stall: results queue in a 4-entry buffer. req_ready drops when queued plus
//   in-flight results would fill it, so nothing is lost while rsp_ready is low.
module laplacian_highpass_3x3_unit #(
   parameter int MAX_ROW_LENGTH = lhp_pkg::MaxRowLengthDefault,
   parameter int MAX_ROWS       = lhp_pkg::MaxRowsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lhp_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lhp_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lhp_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [lhp_pkg::CsrDataWidth-1:0]   csr_wdata
);

   import lhp_pkg::*;

   localparam int ColWidth  = $clog2(MAX_ROW_LENGTH);   // column index
   localparam int ColCmpW   = ColWidth + 1;
   localparam int WidthW    = $clog2(MAX_ROW_LENGTH + 1);
   localparam int WidthCmpW = WidthW + 1;
   localparam int HeightW   = $clog2(MAX_ROWS + 1);
   localparam int RowWidth  = $clog2(MAX_ROWS + 2);      // drain goes to H+1
   localparam int RowCmpW   = RowWidth + 1;
   localparam int PtrW      = $clog2(OutFifoDepth);
   localparam int CntW      = $clog2(OutFifoDepth + 1);
   localparam int RamWidth  = 2 * PixelWidth;

   localparam int WidthReset  = (RowLengthReset < MinDim) ? MinDim :
                                (RowLengthReset > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH :
                                RowLengthReset;
   localparam int HeightReset = (RowCountReset < MinDim) ? MinDim :
                                (RowCountReset > MAX_ROWS) ? MAX_ROWS : RowCountReset;

   // ---------------- configuration ----------------
   logic [WidthW-1:0]         w_eff_ff, w_eff_in;
   logic [HeightW-1:0]        h_eff_ff, h_eff_in;
   logic                      cfg_restart;
   logic [RowLengthWidth-1:0] len_raw;
   logic [RowCountWidth-1:0]  cnt_raw;
   logic [WidthW-1:0]         len_clamped;
   logic [HeightW-1:0]        cnt_clamped;

   assign csr_ready = 1'b1;
   assign len_raw   = csr_wdata[RowLengthWidth-1:0];
   assign cnt_raw   = csr_wdata[RowCountWidth-1:0];

   assign len_clamped = (32'(len_raw) < 32'(MinDim)) ? WidthW'(MinDim) :
                        (32'(len_raw) > 32'(MAX_ROW_LENGTH)) ? WidthW'(MAX_ROW_LENGTH) :
                        WidthW'(len_raw);
   assign cnt_clamped = (32'(cnt_raw) < 32'(MinDim)) ? HeightW'(MinDim) :
                        (32'(cnt_raw) > 32'(MAX_ROWS)) ? HeightW'(MAX_ROWS) :
                        HeightW'(cnt_raw);

   always_comb begin
      w_eff_in    = w_eff_ff;
      h_eff_in    = h_eff_ff;
      cfg_restart = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrRowLength: begin
               w_eff_in    = len_clamped;
               cfg_restart = 1'b1;
            end
            CsrRowCount: begin
               h_eff_in    = cnt_clamped;
               cfg_restart = 1'b1;
            end
            default: ;   // unknown index: ignored
         endcase
      end
   end

   // ---------------- stage 0: position tracking, RAM read ----------------
   logic [ColWidth-1:0] col_ff, col_in;
   logic [RowWidth-1:0] row_ff, row_in;
   logic                item_accept, item_go, draining, drop;
   logic                col_wrap, has_res, interior, frame_end;
   logic [RowWidth-1:0] ctr_row;   // center row of the produced result
   logic [WidthW-1:0]   ctr_col;   // center column of the produced result
   logic [PixelWidth-1:0] px_eff;

   assign item_accept = req_valid && req_ready;
   assign draining    = row_ff >= RowWidth'(h_eff_ff);
   assign drop        = req_payload.flush && !draining;
   assign item_go     = item_accept && !drop;
   assign px_eff      = draining ? '0 : req_payload.pixel_in;

   assign col_wrap = ({1'b0, col_ff} + ColCmpW'(1)) >= ColCmpW'(w_eff_ff);
   // first result needs row_length + 2 items in the frame
   assign has_res  = !(row_ff == '0 || (row_ff == RowWidth'(1) && col_ff == '0));

   // the window center trails the input by one row plus one pixel
   assign ctr_row = (col_ff == '0) ? row_ff - RowWidth'(2) : row_ff - RowWidth'(1);
   assign ctr_col = (col_ff == '0) ? w_eff_ff - WidthW'(1)
                                   : WidthW'(col_ff) - WidthW'(1);

   assign interior = (ctr_row != '0)
                  && (({1'b0, ctr_row} + RowCmpW'(2)) <= RowCmpW'(h_eff_ff))
                  && (ctr_col != '0)
                  && (({1'b0, ctr_col} + WidthCmpW'(2)) <= WidthCmpW'(w_eff_ff));
   assign frame_end = has_res
                   && (ctr_row == RowWidth'(h_eff_ff) - RowWidth'(1))
                   && (ctr_col == w_eff_ff - WidthW'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (item_go) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + RowWidth'(1);
         end else begin
            col_in = col_ff + ColWidth'(1);
         end
      end
   end

   // stage 1 registers
   logic                  s1_valid_ff, s1_res_ff, s1_interior_ff, s1_last_ff;
   logic [PixelWidth-1:0] s1_px_ff;
   logic [ColWidth-1:0]   s1_col_ff;

   // ---------------- line store ----------------
   // [15:8] row above, [7:0] two rows above
   logic [RamWidth-1:0]   ram_rd_data;
   logic [PixelWidth-1:0] top_px, mid_px;

   assign {mid_px, top_px} = ram_rd_data;

   lhp_ram #(
      .WIDTH (RamWidth),
      .DEPTH (MAX_ROW_LENGTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_px_ff, mid_px}),
      .rd_en   (item_go),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------- stage 1: window shift and kernel sum ----------------
   // colm = middle column, colr = right column; index 0 top .. 2 bottom
   logic [PixelWidth-1:0]       colm_ff [3];
   logic [PixelWidth-1:0]       colr_ff [3];
   logic [NeighborSumW-1:0]     nb_sum, center_x8;
   logic signed [SumWidth-1:0]  kernel_sum;

   // after the shift: left = colm, center column = colr, right = new column
   assign nb_sum = NeighborSumW'(colm_ff[0]) + NeighborSumW'(colm_ff[1])
                 + NeighborSumW'(colm_ff[2]) + NeighborSumW'(colr_ff[0])
                 + NeighborSumW'(colr_ff[2]) + NeighborSumW'(top_px)
                 + NeighborSumW'(mid_px)     + NeighborSumW'(s1_px_ff);
   assign center_x8  = {colr_ff[1], {CenterGainShift{1'b0}}};
   assign kernel_sum = $signed({1'b0, center_x8}) - $signed({1'b0, nb_sum});

   // stage 2 registers
   logic                       s2_valid_ff, s2_interior_ff, s2_last_ff;
   logic signed [SumWidth-1:0] s2_sum_ff;
   logic [PixelWidth-1:0]      s2_center_ff;

   // ---------------- stage 2: divide, clamp ----------------
   // negative sums clamp to zero, so truncation toward zero only matters for
   // positive sums, where it is a plain shift; 2040/16 stays below 255
   logic [PixelWidth-1:0] filt_px;
   rsp_payload_type       s2_result;

   assign filt_px = s2_sum_ff[SumWidth-1] ? '0
                  : PixelWidth'(s2_sum_ff[SumWidth-2:DivShift]);
   assign s2_result.pixel_out  = s2_interior_ff ? filt_px : s2_center_ff;
   assign s2_result.frame_last = s2_last_ff;

   // ---------------- result queue ----------------
   rsp_payload_type  fifo_mem_ff [OutFifoDepth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  fifo_count_ff, fifo_count_in;
   logic [CntW-1:0]  occupancy;
   logic             push, pop;

   assign push = s2_valid_ff;
   assign pop  = rsp_valid && rsp_ready;

   assign rsp_valid   = fifo_count_ff != '0;
   assign rsp_payload = fifo_mem_ff[rd_ptr_ff];

   always_comb begin
      fifo_count_in = fifo_count_ff;
      if (push && !pop) begin
         fifo_count_in = fifo_count_ff + CntW'(1);
      end else if (pop && !push) begin
         fifo_count_in = fifo_count_ff - CntW'(1);
      end
   end

   // credit: every result still in the pipe owns a queue slot
   assign occupancy = fifo_count_ff + CntW'(s1_valid_ff & s1_res_ff) + CntW'(s2_valid_ff);
   assign req_ready = occupancy < CntW'(OutFifoDepth);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff      <= WidthW'(WidthReset);
         h_eff_ff      <= HeightW'(HeightReset);
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         w_eff_ff      <= w_eff_in;
         h_eff_ff      <= h_eff_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= item_go;
         s2_valid_ff   <= s1_valid_ff && s1_res_ff;
         fifo_count_ff <= fifo_count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_res_ff      <= has_res;
      s1_interior_ff <= interior;
      s1_last_ff     <= frame_end;
      s1_px_ff       <= px_eff;
      s1_col_ff      <= col_ff;

      if (s1_valid_ff) begin
         colm_ff[0] <= colr_ff[0];
         colm_ff[1] <= colr_ff[1];
         colm_ff[2] <= colr_ff[2];
         colr_ff[0] <= top_px;
         colr_ff[1] <= mid_px;
         colr_ff[2] <= s1_px_ff;
      end

      s2_sum_ff      <= kernel_sum;
      s2_center_ff   <= colr_ff[1];
      s2_interior_ff <= s1_interior_ff;
      s2_last_ff     <= s1_last_ff;

      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= s2_result;
      end
   end

   // ---------------- checks ----------------
   a_col_below_width: assert property (@(posedge clock) disable iff (reset)
      ColCmpW'(col_ff) < ColCmpW'(w_eff_ff))
      else $error("column counter reached row length");

   a_row_bounded: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} <= RowCmpW'(h_eff_ff) + RowCmpW'(1))
      else $error("row counter ran past the drain window");

   // the frame-end item sits at column 0 and the next frame starts there too;
   // that stale read only feeds row 0 of the window, which never reaches a result
   a_no_ram_collision: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && item_go && !s1_last_ff) |-> (s1_col_ff != col_ff))
      else $error("line store read and write-back hit the same column");

   a_queue_has_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (fifo_count_ff < CntW'(OutFifoDepth) || pop))
      else $error("result pushed into a full queue");

   a_cfg_restarts_frame: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == CsrRowLength || csr_index == CsrRowCount))
      |=> (row_ff == '0 && col_ff == '0))
      else $error("register write did not restart the frame");

endmodule

// ----- verif/lhp_result_checker.sv -----
// Result checker for laplacian_highpass_3x3_unit: predicts each filtered pixel
// from the accepted request items and csr writes, and compares it with rsp.
// Depends on lhp_pkg.
`timescale 1ns / 1ps

module lhp_result_checker #(
   parameter int MAX_ROW_LENGTH = lhp_pkg::MaxRowLengthDefault,
   parameter int MAX_ROWS       = lhp_pkg::MaxRowsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  lhp_pkg::req_payload_type           req_payload,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  lhp_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lhp_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [lhp_pkg::CsrDataWidth-1:0]   csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding
);
   import lhp_pkg::*;

   localparam int MaxReports = 10;

   logic [RowLengthWidth-1:0] width_reg;
   logic [RowCountWidth-1:0]  height_reg;
   bit [PixelWidth-1:0]       row_above     [MAX_ROW_LENGTH];
   bit [PixelWidth-1:0]       row_two_above [MAX_ROW_LENGTH];
   bit [PixelWidth-1:0]       taps [9];
   int unsigned               col_pos;
   int unsigned               row_pos;
   int unsigned               out_pos;
   rsp_payload_type           expected_pixels [$];
   int                        errors = 0;

   // One step of the filter: returns 1 when the item yields an output pixel.
   function automatic bit filter_pixel(input req_payload_type item,
                                       output rsp_payload_type res);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned cr;
      int unsigned cc;
      int          k;
      int          acc;
      int          val;
      bit          draining;
      bit [PixelWidth-1:0] px;
      res = '0;
      w = width_reg;
      if (w < MinDim) w = MinDim;
      if (w > MAX_ROW_LENGTH) w = MAX_ROW_LENGTH;
      h = height_reg;
      if (h < MinDim) h = MinDim;
      if (h > MAX_ROWS) h = MAX_ROWS;
      c = col_pos;
      r = row_pos;
      draining = (r >= h);
      // flush inside the frame is dropped
      if (item.flush && !draining) return 1'b0;
      px = draining ? '0 : item.pixel_in;
      if (c >= MAX_ROW_LENGTH) c = 0;

      for (k = 0; k < 3; k++) begin
         taps[k*3]     = taps[k*3 + 1];
         taps[k*3 + 1] = taps[k*3 + 2];
      end
      taps[2] = row_two_above[c];
      taps[5] = row_above[c];
      taps[8] = px;
      row_two_above[c] = row_above[c];
      row_above[c]     = px;

      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end

      if (r == 0 || (r == 1 && c == 0)) return 1'b0;

      if (c == 0) begin
         cr = r - 2;
         cc = w - 1;
      end else begin
         cr = r - 1;
         cc = c - 1;
      end

      if (cr >= 1 && cr + 2 <= h && cc >= 1 && cc + 2 <= w) begin
         acc = 8 * int'(taps[4]);
         for (k = 0; k < 9; k++)
            if (k != 4) acc -= int'(taps[k]);
         val = acc / 16;
         if (val < 0) val = 0;
         if (val > 255) val = 255;
      end else begin
         val = int'(taps[4]);
      end

      res.pixel_out = val[PixelWidth-1:0];
      if (out_pos + 1 >= w * h) begin
         res.frame_last = 1'b1;
         col_pos = 0;
         row_pos = 0;
         out_pos = 0;
      end else begin
         res.frame_last = 1'b0;
         out_pos = (out_pos + 1) & 32'h003F_FFFF;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : track
      rsp_payload_type predicted;
      rsp_payload_type want;
      if (reset) begin
         width_reg  = RowLengthWidth'(RowLengthReset);
         height_reg = RowCountWidth'(RowCountReset);
         foreach (taps[k]) taps[k] = '0;
         col_pos = 0;
         row_pos = 0;
         out_pos = 0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               if (errors < MaxReports)
                  $display("%0t: unexpected rsp item: pixel %0d last %0b", $time,
                           rsp_payload.pixel_out, rsp_payload.frame_last);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_payload.pixel_out !== want.pixel_out ||
                   rsp_payload.frame_last !== want.frame_last) begin
                  if (errors < MaxReports)
                     $display("%0t: rsp mismatch: exp pixel %0d last %0b, got %0d last %0b",
                              $time, want.pixel_out, want.frame_last,
                              rsp_payload.pixel_out, rsp_payload.frame_last);
                  errors++;
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrRowLength: begin
                  width_reg = csr_wdata[RowLengthWidth-1:0];
                  col_pos = 0;
                  row_pos = 0;
                  out_pos = 0;
               end
               CsrRowCount: begin
                  height_reg = csr_wdata[RowCountWidth-1:0];
                  col_pos = 0;
                  row_pos = 0;
                  out_pos = 0;
               end
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            if (filter_pixel(req_payload, predicted))
               expected_pixels.push_back(predicted);
         end
      end
      outstanding <= expected_pixels.size();
      fail_count  <= errors;
   end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for laplacian_highpass_3x3_unit: drives req/csr stimulus and
// random rsp back-pressure, and gives the verdict.
// Depends on lhp_pkg, the unit RTL and lhp_result_checker.
`timescale 1ns / 1ps

module tb_top;
   import lhp_pkg::*;

   localparam int ClockPeriod    = 10;
   localparam int ResetCycles    = 8;
   localparam int SettleCycles   = 8;       // outlasts the item-to-rsp pipeline
   localparam int LongHoldCycles = 120;     // long rsp stall, fills the 4-entry queue
   localparam int RandomItems    = 1150;
   localparam int QuietTail      = 150;     // last items run with no idling
   localparam int TimeoutNs      = 5_000_000;
   localparam int WidePhase      = 1;
   localparam int TallPhase      = 2;
   localparam int HoldPhase      = 3;
   localparam int WideItems      = 40;
   // csr index past the register list; the unit must ignore it
   localparam logic [CsrIndexWidth-1:0] CsrSpare = 2'd2;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_payload_type            req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CsrIndexWidth-1:0]   csr_index = '0;
   logic [CsrDataWidth-1:0]    csr_wdata = '0;

   logic                       quiet = 1'b0;          // no idling on either side
   logic                       long_hold_req = 1'b0;  // asks the rsp side for one long stall
   int                         fail_count;
   int                         outstanding;

   int unsigned                gap_odds = 0;          // 0 = sender never idles
   int unsigned                noise_odds = 0;        // 0 = no stray flush items
   int unsigned                scored_items = 0;

   always #(ClockPeriod / 2) clock = ~clock;

   laplacian_highpass_3x3_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   lhp_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Offer one item; returns at the edge where it is taken. Valid stays high
   // afterwards so back-to-back items never drop it within a step.
   task automatic send_item(input logic [PixelWidth-1:0] px, input logic fl);
      req_payload_type item;
      item.pixel_in = px;
      item.flush    = fl;
      if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every predicted pixel has come back, then
   // wait SettleCycles more so dropped items still in the pipe are gone too.
   // The outstanding count is registered, hence the first wait on the clock.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // csr write; valid only drops after the last of a burst of writes
   task automatic csr_write(input logic [CsrIndexWidth-1:0] idx, input int unsigned data,
                            input bit drop_valid);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CsrDataWidth-1:0];
      do @(posedge clock); while (!csr_ready);
      if (drop_valid) csr_valid <= 1'b0;
   endtask

   // 3x3 frame: ring value on the border, one center pixel, then 4 drain
   // items (alternating flush and pixel items whose value is ignored).
   task automatic send_grid(input logic [PixelWidth-1:0] center,
                            input logic [PixelWidth-1:0] ring, input bit early_flush);
      for (int i = 0; i < 9; i++) begin
         send_item((i == 4) ? center : ring, 1'b0);
         if (early_flush && i == 5) send_item(8'h00, 1'b1);   // inside frame: dropped
      end
      for (int i = 0; i < 4; i++)
         send_item(PixelWidth'($urandom_range(0, 255)), (i % 2) == 0);
   endtask

   // A run of pixels then a run of drain items. Pixel content mixes a flat
   // tone with noise and hard 0/255 spikes so the kernel sees real edges.
   task automatic run_frame(input int unsigned pixels, input int unsigned drains,
                            input bit spare_write);
      int unsigned tone;
      int unsigned px;
      tone = $urandom_range(0, 255);
      for (int unsigned i = 0; i < pixels; i++) begin
         if (spare_write && i == pixels / 2) begin
            // unknown register index mid-frame: frame must carry on untouched
            wait_idle();
            csr_write(CsrSpare, $urandom_range(0, 8191), 1'b1);
         end
         if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
            send_item(PixelWidth'($urandom_range(0, 255)), 1'b1);
         case ($urandom_range(0, 3))
            0:       px = $urandom_range(0, 255);
            1:       px = $urandom_range(0, 1) ? 255 : 0;
            default: begin
               px = tone + $urandom_range(0, 24);
               px = (px < 12) ? 0 : px - 12;
               if (px > 255) px = 255;
            end
         endcase
         send_item(px[PixelWidth-1:0], 1'b0);
      end
      // past the last pixel both flush and pixel items drain
      for (int unsigned i = 0; i < drains; i++)
         send_item(PixelWidth'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // Receiver: random stall bursts, calm stretches, one long hold on request.
   initial begin : rsp_side
      int  calm;
      bit  long_hold_seen;
      calm = 0;
      long_hold_seen = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_seen) begin
            long_hold_seen = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && calm == 0 && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
            if (calm != 0) calm--;
            else if ($urandom_range(0, 99) == 0) calm = $urandom_range(50, 150);
         end
      end
   end

   initial begin : watchdog
      #(TimeoutNs);
      $display("laplacian_highpass_3x3_unit test failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned wval;
      int unsigned hval;
      int unsigned ew;
      int unsigned eh;
      int unsigned frames;
      int unsigned shape;
      int unsigned pixels;
      int unsigned drains;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // Unknown index is ignored; 0 and 2 clamp up to the 3x3 minimum frame.
      csr_write(CsrSpare, 8191, 1'b0);
      csr_write(CsrRowLength, 0, 1'b0);
      csr_write(CsrRowCount, 2, 1'b1);
      // bright center on black: 8*255/16 = 127; stray flush inside the frame
      send_grid(8'hFF, 8'h00, 1'b1);
      // dark center on white: negative sum clamps to 0
      send_grid(8'h00, 8'hFF, 1'b0);
      wait_idle();

      // ---- random part ----
      phase = 0;
      while (scored_items < RandomItems) begin
         phase++;
         if (!quiet && scored_items + QuietTail >= RandomItems) quiet <= 1'b1;

         // frame geometry, written only while the unit is idle
         if (phase == WidePhase) begin
            wval = 2047;                 // clamps to 1024
            hval = 3;
         end else if (phase == TallPhase) begin
            wval = 3;
            hval = 8191;                 // clamps to 4096
         end else if (phase == HoldPhase) begin
            wval = 12;
            hval = 8;
         end else begin
            wval = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            hval = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         end
         ew = (wval < MinDim) ? MinDim : wval;
         eh = (hval < MinDim) ? MinDim : hval;

         wait_idle();
         if ($urandom_range(0, 1)) begin
            csr_write(CsrRowLength, wval, 1'b0);
            csr_write(CsrRowCount, hval, 1'b1);
         end else begin
            csr_write(CsrRowCount, hval, 1'b0);
            csr_write(CsrRowLength, wval, 1'b1);
         end

         case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 2;
            default: gap_odds = 6;
         endcase
         noise_odds = ($urandom_range(0, 3) == 0) ? 20 : 0;

         if (phase == WidePhase) begin
            // a short stretch of the first 1024-pixel row: no result may
            // show up yet; frame is abandoned by the next csr write
            gap_odds = 0;
            noise_odds = 0;
            run_frame(WideItems, 0, 1'b0);
            scored_items += WideItems;
         end else if (phase == TallPhase) begin
            run_frame(60, 0, 1'b0);
            scored_items += 60;
         end else if (phase == HoldPhase) begin
            // receiver stalls long while the sender keeps pushing
            gap_odds = 0;
            noise_odds = 0;
            long_hold_req <= 1'b1;
            run_frame(ew * eh, ew + 1, 1'b0);
            scored_items += ew * eh + ew + 1;
         end else begin
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++) begin
               shape = $urandom_range(0, 9);
               if (shape < 7) begin
                  // well-formed frame with exact drain
                  pixels = ew * eh;
                  drains = ew + 1;
               end else if (shape == 7) begin
                  // drain too short or too long: next frame starts misaligned
                  pixels = ew * eh;
                  drains = $urandom_range(0, ew + 4);
               end else begin
                  // truncated frame
                  pixels = $urandom_range(1, ew * eh - 1);
                  drains = $urandom_range(0, 2);
               end
               run_frame(pixels, drains, $urandom_range(0, 5) == 0);
               scored_items += pixels + drains;
            end
         end
      end

      wait_idle();
      if (fail_count == 0 && outstanding == 0)
         $display("laplacian_highpass_3x3_unit test passed");
      else
         $display("laplacian_highpass_3x3_unit test failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/lhp_pkg.sv
rtl/core/lhp_ram.sv
rtl/core/laplacian_highpass_3x3_unit.sv
verif/lhp_result_checker.sv
verif/tb_top.sv
